/* hw/rtl/rkh_pkg.sv */
// ----------------------------------------------------------------------------
// rkh_pkg - remote key hold controller shared definitions
// Key codes, register indexes and reset values, and the structs that carry
// one tick item, one result and the configuration between modules.
// ----------------------------------------------------------------------------
package rkh_pkg;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   // key codes
   localparam logic [7:0] KEY_UNLOCK = 8'd1;
   localparam logic [7:0] KEY_LOCK   = 8'd2;
   localparam logic [7:0] KEY_CALIB  = 8'd3;
   localparam logic [7:0] KEY_ALARM  = 8'd4;
   localparam logic [7:0] KEY_CHILD  = 8'd8;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_LOCK_HOLD  = 3'd0;
   localparam logic [2:0] REG_CHILD_HOLD = 3'd1;
   localparam logic [2:0] REG_CALIB_HOLD = 3'd2;
   localparam logic [2:0] REG_ALARM_HOLD = 3'd3;
   localparam logic [2:0] REG_RELEASE    = 3'd4;
   localparam logic [2:0] REG_CALIB_RUN  = 3'd5;

   // register reset values
   localparam logic [7:0]  RST_LOCK_HOLD  = 8'd8;
   localparam logic [7:0]  RST_CHILD_HOLD = 8'd10;
   localparam logic [15:0] RST_CALIB_HOLD = 16'd1500;
   localparam logic [7:0]  RST_ALARM_HOLD = 8'd80;
   localparam logic [7:0]  RST_RELEASE    = 8'd180;
   localparam logic [15:0] RST_CALIB_RUN  = 16'd80;

   localparam logic [7:0] HOLD_MAX = 8'd255;

   typedef struct packed {
      logic [7:0]  lock_hold_ticks;
      logic [7:0]  child_hold_ticks;
      logic [15:0] calib_hold_ticks;
      logic [7:0]  alarm_hold_ticks;
      logic [7:0]  release_ticks;
      logic [15:0] calib_run_ticks;
   } cfg_type;

   typedef struct packed {
      logic [7:0] key_primary;
      logic [7:0] key_secondary;
      logic       pad_busy_a;
      logic       pad_busy_b;
      logic       motor_run_a;
      logic       motor_run_b;
   } item_type;

   typedef struct packed {
      logic alarm_on;
      logic locked;
      logic child_mode;
      logic child_toggle_pulse;
      logic calibrating;
   } result_type;

endpackage

/* hw/rtl/remote_key_hold_controller.sv */
// Path: an accepted transaction is held in the input register, then its result
//   moves into the result register when that register is free or drains.
// Throughput: one transaction per cycle while rsp_ready is high; the per-tick logic
//   between the two registers is a handful of 8- and 16-bit compares and increments.
// Reset: clears all key, alarm, lock and calibration state and loads the
//   register defaults; no clearing pass, transactions accepted right after reset.
// ----------------------------------------------------------------------------
// remote_key_hold_controller - remote key hold controller top level
// Input register, per-tick logic with state, result register, and the
// configuration registers.
// ----------------------------------------------------------------------------
module remote_key_hold_controller
   import rkh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // tick input channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_key_primary,
   input  logic [7:0]              req_key_secondary,
   input  logic                    req_pad_busy_a,
   input  logic                    req_pad_busy_b,
   input  logic                    req_motor_run_a,
   input  logic                    req_motor_run_b,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_alarm_on,
   output logic                    rsp_locked,
   output logic                    rsp_child_mode,
   output logic                    rsp_child_toggle_pulse,
   output logic                    rsp_calibrating,
   // configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff, item_valid_in;
   result_type tick_result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;

   // item moves into the result register when that register is free or drains
   assign advance   = item_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~item_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   assign item_valid_in = req_take | (item_valid_ff & ~advance);
   assign rsp_valid_in  = advance | (rsp_valid_ff & ~rsp_ready);

   rkh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rkh_tick u_tick (
      .clock   (clock),
      .reset   (reset),
      .tick_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (tick_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.key_primary   <= req_key_primary;
         item_ff.key_secondary <= req_key_secondary;
         item_ff.pad_busy_a    <= req_pad_busy_a;
         item_ff.pad_busy_b    <= req_pad_busy_b;
         item_ff.motor_run_a   <= req_motor_run_a;
         item_ff.motor_run_b   <= req_motor_run_b;
      end
      if (advance) begin
         result_ff <= tick_result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_alarm_on           = result_ff.alarm_on;
   assign rsp_locked             = result_ff.locked;
   assign rsp_child_mode         = result_ff.child_mode;
   assign rsp_child_toggle_pulse = result_ff.child_toggle_pulse;
   assign rsp_calibrating        = result_ff.calibrating;

endmodule

/* hw/rtl/rkh_csr.sv */
// ----------------------------------------------------------------------------
// rkh_csr - configuration registers
// APB-style register file holding the six hold and run thresholds.
// ----------------------------------------------------------------------------
module rkh_csr
   import rkh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_LOCK_HOLD:  cfg_in.lock_hold_ticks  = csr_pwdata[7:0];
            REG_CHILD_HOLD: cfg_in.child_hold_ticks = csr_pwdata[7:0];
            REG_CALIB_HOLD: cfg_in.calib_hold_ticks = csr_pwdata[15:0];
            REG_ALARM_HOLD: cfg_in.alarm_hold_ticks = csr_pwdata[7:0];
            REG_RELEASE:    cfg_in.release_ticks    = csr_pwdata[7:0];
            REG_CALIB_RUN:  cfg_in.calib_run_ticks  = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LOCK_HOLD:  csr_prdata = {24'd0, cfg_ff.lock_hold_ticks};
         REG_CHILD_HOLD: csr_prdata = {24'd0, cfg_ff.child_hold_ticks};
         REG_CALIB_HOLD: csr_prdata = {16'd0, cfg_ff.calib_hold_ticks};
         REG_ALARM_HOLD: csr_prdata = {24'd0, cfg_ff.alarm_hold_ticks};
         REG_RELEASE:    csr_prdata = {24'd0, cfg_ff.release_ticks};
         REG_CALIB_RUN:  csr_prdata = {16'd0, cfg_ff.calib_run_ticks};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lock_hold_ticks  <= RST_LOCK_HOLD;
         cfg_ff.child_hold_ticks <= RST_CHILD_HOLD;
         cfg_ff.calib_hold_ticks <= RST_CALIB_HOLD;
         cfg_ff.alarm_hold_ticks <= RST_ALARM_HOLD;
         cfg_ff.release_ticks    <= RST_RELEASE;
         cfg_ff.calib_run_ticks  <= RST_CALIB_RUN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/rkh_tick.sv */
// ----------------------------------------------------------------------------
// rkh_tick - per-tick key, alarm, lock, child and calibration logic
// Holds the controller state and computes the next state and the result of
// one tick; state advances when the tick is committed.
// ----------------------------------------------------------------------------
module rkh_tick
   import rkh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tick_en,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic        alarm_flag_ff,         alarm_flag_in;
   logic [7:0]  alarm_counter_ff,      alarm_counter_in;
   logic [7:0]  key_hold_counter_ff,   key_hold_counter_in;
   logic [7:0]  release_counter_ff,    release_counter_in;
   logic [15:0] calib_hold_counter_ff, calib_hold_counter_in;
   logic [15:0] calib_run_counter_ff,  calib_run_counter_in;
   logic        lock_latch_ff,         lock_latch_in;
   logic        child_latch_ff,        child_latch_in;
   logic        calib_started_ff,      calib_started_in;
   logic        lock_state_ff,         lock_state_in;
   logic        child_state_ff,        child_state_in;
   logic        calib_active_ff,       calib_active_in;

   logic [7:0] key;
   logic       gated;
   logic       pulse;
   logic [7:0] hold_inc;

   assign key   = (item.key_primary != 8'd0) ? item.key_primary : item.key_secondary;
   assign gated = ~(item.pad_busy_a | item.pad_busy_b | item.motor_run_a | item.motor_run_b)
                  | lock_state_ff;
   // hold counter saturates
   assign hold_inc = (key_hold_counter_ff < HOLD_MAX) ? key_hold_counter_ff + 8'd1
                                                      : key_hold_counter_ff;

   always_comb begin
      alarm_flag_in         = alarm_flag_ff;
      alarm_counter_in      = alarm_counter_ff;
      key_hold_counter_in   = key_hold_counter_ff;
      release_counter_in    = release_counter_ff;
      calib_hold_counter_in = calib_hold_counter_ff;
      calib_run_counter_in  = calib_run_counter_ff;
      lock_latch_in         = lock_latch_ff;
      child_latch_in        = child_latch_ff;
      calib_started_in      = calib_started_ff;
      lock_state_in         = lock_state_ff;
      child_state_in        = child_state_ff;
      calib_active_in       = calib_active_ff;
      pulse                 = 1'b0;

      // alarm runs on every tick
      if (key == KEY_ALARM) begin
         alarm_flag_in    = 1'b1;
         alarm_counter_in = 8'd0;
      end else if (alarm_counter_ff >= cfg.alarm_hold_ticks) begin
         alarm_flag_in = 1'b0;
      end else begin
         alarm_counter_in = alarm_counter_ff + 8'd1;
      end

      if (gated) begin
         case (key)
            KEY_LOCK, KEY_UNLOCK: begin
               if (key_hold_counter_ff > cfg.lock_hold_ticks) begin
                  if (!lock_latch_ff) begin
                     lock_latch_in = 1'b1;
                     lock_state_in = (key == KEY_LOCK) ? ~lock_state_ff : 1'b0;
                  end
               end else begin
                  key_hold_counter_in = hold_inc;
               end
               release_counter_in = 8'd0;
            end
            KEY_CHILD: begin
               if (key_hold_counter_ff > cfg.child_hold_ticks) begin
                  if (!child_latch_ff) begin
                     child_latch_in = 1'b1;
                     child_state_in = ~child_state_ff;
                     pulse          = 1'b1;
                  end
               end else begin
                  key_hold_counter_in = hold_inc;
               end
               release_counter_in = 8'd0;
            end
            KEY_CALIB: begin
               if (calib_hold_counter_ff >= cfg.calib_hold_ticks) begin
                  calib_hold_counter_in = 16'd0;
                  calib_started_in      = 1'b1;
                  calib_active_in       = 1'b1;
               end else begin
                  calib_hold_counter_in = calib_hold_counter_ff + 16'd1;
               end
               release_counter_in = 8'd0;
            end
            default: begin
               // any other key, the alarm key included: count toward re-arming the latches
               if (release_counter_ff >= cfg.release_ticks) begin
                  release_counter_in = 8'd0;
                  child_latch_in     = 1'b0;
                  lock_latch_in      = 1'b0;
               end else begin
                  release_counter_in = release_counter_ff + 8'd1;
               end
               calib_hold_counter_in = 16'd0;
               key_hold_counter_in   = 8'd0;
            end
         endcase

         // run timer sees the activity set by this tick's key
         if (calib_active_in) begin
            if (calib_run_counter_ff >= cfg.calib_run_ticks) begin
               if (calib_started_in) begin
                  calib_active_in = 1'b0;
               end
            end else begin
               calib_run_counter_in = calib_run_counter_ff + 16'd1;
            end
         end else begin
            calib_run_counter_in = 16'd0;
         end
      end
   end

   assign result.alarm_on           = alarm_flag_in;
   assign result.locked             = lock_state_in;
   assign result.child_mode         = child_state_in;
   assign result.child_toggle_pulse = pulse;
   assign result.calibrating        = calib_active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_flag_ff         <= 1'b0;
         alarm_counter_ff      <= 8'd0;
         key_hold_counter_ff   <= 8'd0;
         release_counter_ff    <= 8'd0;
         calib_hold_counter_ff <= 16'd0;
         calib_run_counter_ff  <= 16'd0;
         lock_latch_ff         <= 1'b0;
         child_latch_ff        <= 1'b0;
         calib_started_ff      <= 1'b0;
         lock_state_ff         <= 1'b0;
         child_state_ff        <= 1'b0;
         calib_active_ff       <= 1'b0;
      end else if (tick_en) begin
         alarm_flag_ff         <= alarm_flag_in;
         alarm_counter_ff      <= alarm_counter_in;
         key_hold_counter_ff   <= key_hold_counter_in;
         release_counter_ff    <= release_counter_in;
         calib_hold_counter_ff <= calib_hold_counter_in;
         calib_run_counter_ff  <= calib_run_counter_in;
         lock_latch_ff         <= lock_latch_in;
         child_latch_ff        <= child_latch_in;
         calib_started_ff      <= calib_started_in;
         lock_state_ff         <= lock_state_in;
         child_state_ff        <= child_state_in;
         calib_active_ff       <= calib_active_in;
      end
   end

   // a toggle pulse really flips child mode
   a_pulse_toggles: assert property (@(posedge clock) disable iff (reset)
      !reset && tick_en && pulse |=> child_state_ff != $past(child_state_ff))
      else $error("child toggle pulse without child mode change");

   // calibration only runs once it has been started
   a_calib_started: assert property (@(posedge clock) disable iff (reset)
      calib_active_ff |-> calib_started_ff)
      else $error("calibration active without start");

   // alarm key always raises the alarm on the committed tick
   a_alarm_raise: assert property (@(posedge clock) disable iff (reset)
      !reset && tick_en && key == KEY_ALARM |=> alarm_flag_ff && alarm_counter_ff == 8'd0)
      else $error("alarm key did not raise alarm");

   // state holds when no transaction is committed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && !tick_en |=> $stable(lock_state_ff) && $stable(child_state_ff)
                             && $stable(key_hold_counter_ff))
      else $error("state changed without a transaction");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - remote key hold controller testbench
// Drives tick transactions through the valid/ready input channel and
// predicts the alarm, lock, child mode and calibration status for every
// accepted tick. Each returned status is compared against the oldest
// prediction. The run walks through several register settings: defaults,
// small holds, zero and maximum values, and saturated hold counts. Random
// idling is applied on both channels, and the status side is held off for
// long stretches.
// ----------------------------------------------------------------------------
module tb_top;
   import rkh_pkg::*;

   localparam int HOLDOFF_CYCLES = 50;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [7:0]              req_key_primary;
   logic [7:0]              req_key_secondary;
   logic                    req_pad_busy_a;
   logic                    req_pad_busy_b;
   logic                    req_motor_run_a;
   logic                    req_motor_run_b;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_alarm_on;
   logic                    rsp_locked;
   logic                    rsp_child_mode;
   logic                    rsp_child_toggle_pulse;
   logic                    rsp_calibrating;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   remote_key_hold_controller dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_key_primary        (req_key_primary),
      .req_key_secondary      (req_key_secondary),
      .req_pad_busy_a         (req_pad_busy_a),
      .req_pad_busy_b         (req_pad_busy_b),
      .req_motor_run_a        (req_motor_run_a),
      .req_motor_run_b        (req_motor_run_b),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_alarm_on           (rsp_alarm_on),
      .rsp_locked             (rsp_locked),
      .rsp_child_mode         (rsp_child_mode),
      .rsp_child_toggle_pulse (rsp_child_toggle_pulse),
      .rsp_calibrating        (rsp_calibrating),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   // predicted controller state and register copy
   cfg_type     csr_shadow;
   logic        alarm_active;
   logic [7:0]  alarm_count;
   logic [7:0]  hold_count;
   logic [7:0]  release_count;
   logic [15:0] calib_hold_count;
   logic [15:0] calib_run_count;
   logic        lock_fired;
   logic        child_fired;
   logic        calib_started;
   logic        lock_on;
   logic        child_on;
   logic        calib_on;

   result_type  expected_status[$];
   int          error_count;
   int          items_sent;
   bit          sender_idling;
   bit          sink_idling;
   bit          stall_request;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic clear_model();
      csr_shadow.lock_hold_ticks  = RST_LOCK_HOLD;
      csr_shadow.child_hold_ticks = RST_CHILD_HOLD;
      csr_shadow.calib_hold_ticks = RST_CALIB_HOLD;
      csr_shadow.alarm_hold_ticks = RST_ALARM_HOLD;
      csr_shadow.release_ticks    = RST_RELEASE;
      csr_shadow.calib_run_ticks  = RST_CALIB_RUN;
      alarm_active     = 1'b0;
      alarm_count      = '0;
      hold_count       = '0;
      release_count    = '0;
      calib_hold_count = '0;
      calib_run_count  = '0;
      lock_fired       = 1'b0;
      child_fired      = 1'b0;
      calib_started    = 1'b0;
      lock_on          = 1'b0;
      child_on         = 1'b0;
      calib_on         = 1'b0;
   endtask

   // one control tick of the key logic, returns the status it reports
   function automatic result_type advance_key_logic(input item_type t);
      logic [7:0] key;
      logic       gated;
      result_type r;
      key = (t.key_primary != 8'd0) ? t.key_primary : t.key_secondary;
      gated = !(t.pad_busy_a | t.pad_busy_b | t.motor_run_a | t.motor_run_b) || lock_on;
      r = '0;

      // alarm runs whether gated or not
      if (key == KEY_ALARM) begin
         alarm_active = 1'b1;
         alarm_count  = 8'd0;
      end else if (alarm_count >= csr_shadow.alarm_hold_ticks) begin
         alarm_active = 1'b0;
      end else begin
         alarm_count = alarm_count + 8'd1;
      end

      if (gated) begin
         case (key)
            KEY_LOCK, KEY_UNLOCK: begin
               if (hold_count > csr_shadow.lock_hold_ticks) begin
                  if (!lock_fired) begin
                     lock_fired = 1'b1;
                     lock_on    = (key == KEY_LOCK) ? !lock_on : 1'b0;
                  end
               end else if (hold_count != HOLD_MAX) begin
                  hold_count = hold_count + 8'd1;
               end
               release_count = 8'd0;
            end
            KEY_CHILD: begin
               if (hold_count > csr_shadow.child_hold_ticks) begin
                  if (!child_fired) begin
                     child_fired          = 1'b1;
                     child_on             = !child_on;
                     r.child_toggle_pulse = 1'b1;
                  end
               end else if (hold_count != HOLD_MAX) begin
                  hold_count = hold_count + 8'd1;
               end
               release_count = 8'd0;
            end
            KEY_CALIB: begin
               // key hold count is left alone here
               if (calib_hold_count >= csr_shadow.calib_hold_ticks) begin
                  calib_hold_count = '0;
                  calib_started    = 1'b1;
                  calib_on         = 1'b1;
               end else begin
                  calib_hold_count = calib_hold_count + 16'd1;
               end
               release_count = 8'd0;
            end
            default: begin
               if (release_count >= csr_shadow.release_ticks) begin
                  release_count = 8'd0;
                  child_fired   = 1'b0;
                  lock_fired    = 1'b0;
               end else begin
                  release_count = release_count + 8'd1;
               end
               calib_hold_count = '0;
               hold_count       = '0;
            end
         endcase

         // run counter only clears on a gated tick with calibration off
         if (calib_on) begin
            if (calib_run_count >= csr_shadow.calib_run_ticks) begin
               if (calib_started) calib_on = 1'b0;
            end else begin
               calib_run_count = calib_run_count + 16'd1;
            end
         end else begin
            calib_run_count = '0;
         end
      end

      r.alarm_on    = alarm_active;
      r.locked      = lock_on;
      r.child_mode  = child_on;
      r.calibrating = calib_on;
      return r;
   endfunction

   function automatic int pick_gap(input bit idling);
      int r;
      r = $urandom_range(0, 99);
      if (!idling || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // entered and left at a rising edge; valid stays high after acceptance
   task automatic send_tick(input item_type t);
      int gap;
      gap = pick_gap(sender_idling);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_key_primary   <= t.key_primary;
      req_key_secondary <= t.key_secondary;
      req_pad_busy_a    <= t.pad_busy_a;
      req_pad_busy_b    <= t.pad_busy_b;
      req_motor_run_a   <= t.motor_run_a;
      req_motor_run_b   <= t.motor_run_b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_status.push_back(advance_key_logic(t));
      items_sent++;
   endtask

   // pauses the sender until every predicted status has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_LOCK_HOLD:  csr_shadow.lock_hold_ticks  = value[7:0];
         REG_CHILD_HOLD: csr_shadow.child_hold_ticks = value[7:0];
         REG_CALIB_HOLD: csr_shadow.calib_hold_ticks = value[15:0];
         REG_ALARM_HOLD: csr_shadow.alarm_hold_ticks = value[7:0];
         REG_RELEASE:    csr_shadow.release_ticks    = value[7:0];
         REG_CALIB_RUN:  csr_shadow.calib_run_ticks  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] lock_hold, input logic [7:0] child_hold,
                                 input logic [15:0] calib_hold, input logic [7:0] alarm_hold,
                                 input logic [7:0] release_hold, input logic [15:0] calib_run);
      wait_drained();
      // upper bits carry junk on some writes, only the register width counts
      write_reg(REG_LOCK_HOLD,  {16'($urandom_range(0, 16'hFFFF)), 8'h00, lock_hold});
      write_reg(REG_CHILD_HOLD, {16'($urandom_range(0, 16'hFFFF)), 8'h00, child_hold});
      write_reg(REG_CALIB_HOLD, {16'($urandom), calib_hold});
      write_reg(REG_ALARM_HOLD, {24'h000000, alarm_hold});
      write_reg(REG_RELEASE,    {24'($urandom), release_hold});
      write_reg(REG_CALIB_RUN,  {16'h0000, calib_run});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic item_type make_tick(input logic [7:0] key, input bit via_secondary,
                                          input bit busy);
      item_type t;
      t.key_primary   = via_secondary ? 8'd0 : key;
      t.key_secondary = via_secondary ? key : ((key == 8'd0) ? 8'd0 : 8'($urandom));
      {t.pad_busy_a, t.pad_busy_b, t.motor_run_a, t.motor_run_b} =
         busy ? 4'($urandom_range(1, 15)) : 4'h0;
      return t;
   endfunction

   task automatic send_run(input logic [7:0] key, input bit via_secondary, input bit busy,
                           input int n);
      repeat (n) send_tick(make_tick(key, via_secondary, busy));
   endtask

   function automatic logic [7:0] pick_command_key();
      case ($urandom_range(0, 4))
         0:       return KEY_LOCK;
         1:       return KEY_UNLOCK;
         2:       return KEY_CHILD;
         3:       return KEY_CALIB;
         default: return KEY_ALARM;
      endcase
   endfunction

   function automatic logic [7:0] pick_release_key();
      logic [7:0] k;
      if ($urandom_range(0, 1) == 0) return 8'd0;
      k = 8'($urandom_range(0, 255));
      while (k == KEY_UNLOCK || k == KEY_LOCK || k == KEY_CALIB || k == KEY_ALARM ||
             k == KEY_CHILD)
         k = 8'($urandom_range(0, 255));
      return k;
   endfunction

   // press lengths cluster around the hold that makes the key act
   function automatic int press_length(input logic [7:0] key);
      int thr;
      case (key)
         KEY_LOCK, KEY_UNLOCK: thr = csr_shadow.lock_hold_ticks;
         KEY_CHILD:            thr = csr_shadow.child_hold_ticks;
         KEY_CALIB:            thr = csr_shadow.calib_hold_ticks;
         default:              thr = 2;
      endcase
      if (thr <= 40 && $urandom_range(0, 1) == 0) return thr + $urandom_range(1, 3);
      return $urandom_range(1, ((thr > 40) ? 40 : thr) + 3);
   endfunction

   task automatic run_random(input int n_items);
      int         stop_at;
      int         len;
      int         rel_max;
      logic [7:0] k;
      bit         via_secondary;
      bit         busy_press;
      item_type   t;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) sender_idling = !sender_idling;
         if ($urandom_range(0, 7) == 0) sink_idling = !sink_idling;
         if ($urandom_range(0, 99) < 75) begin
            // press, hold, release
            k             = pick_command_key();
            via_secondary = ($urandom_range(0, 3) == 0);
            busy_press    = ($urandom_range(0, 5) == 0);
            len           = press_length(k);
            repeat (len)
               send_tick(make_tick(k, via_secondary,
                                   busy_press || ($urandom_range(0, 15) == 0)));
            rel_max = csr_shadow.release_ticks + 3;
            if (rel_max > 40) rel_max = 40;
            len = $urandom_range(1, rel_max);
            repeat (len)
               send_tick(make_tick(pick_release_key(), 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 9) == 0));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               t = item_type'(20'($urandom));
               send_tick(t);
            end
         end
      end
   endtask

   task automatic test_default_settings();
      sender_idling = 1'b1;
      sink_idling   = 1'b1;
      run_random(40);
   endtask

   task automatic test_directed();
      apply_settings(8'd2, 8'd3, 16'd3, 8'd3, 8'd2, 16'd4);
      send_run(KEY_LOCK, 1'b0, 1'b0, 4);
      send_run(KEY_LOCK, 1'b0, 1'b0, 1);
      send_run(8'd0, 1'b0, 1'b0, 3);
      send_run(KEY_UNLOCK, 1'b1, 1'b0, 4);
      send_run(KEY_CHILD, 1'b0, 1'b0, 5);
      send_run(KEY_CALIB, 1'b1, 1'b0, 4);
      // alarm acts with every busy and run bit set
      send_tick({KEY_ALARM, 8'hFF, 4'hF});
      send_run(KEY_LOCK, 1'b0, 1'b1, 2);
      send_tick({8'h00, 8'hFF, 4'h0});
      send_tick({8'hFF, 8'h00, 4'hF});
   endtask

   task automatic test_backpressure();
      wait_drained();
      sender_idling = 1'b0;
      stall_request = 1'b1;
      send_run(KEY_CHILD, 1'b0, 1'b0, 12);
      send_run(8'd0, 1'b0, 1'b0, 12);
      wait_drained();
      sender_idling = 1'b1;
      run_random(30);
   endtask

   // hold count saturates at max, lock hold just below it still acts
   task automatic test_hold_saturation();
      apply_settings(8'd254, 8'd255, 16'd5, 8'd10, 8'd0, 16'd3);
      sender_idling = 1'b0;
      send_run(8'd0, 1'b0, 1'b0, 1);
      send_run(KEY_CHILD, 1'b0, 1'b0, 258);
      send_run(KEY_LOCK, 1'b0, 1'b0, 3);
      sender_idling = 1'b1;
      send_run(8'd0, 1'b1, 1'b0, 2);
   endtask

   task automatic test_settings_sweep();
      apply_settings(8'd3, 8'd5, 16'd6, 8'd4, 8'd5, 16'd7);
      run_random(70);
      apply_settings(8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 16'd0);
      run_random(70);
      apply_settings(8'd1, 8'd2, 16'hFFFF, 8'd255, 8'd255, 16'hFFFF);
      run_random(60);
      apply_settings(8'($urandom_range(0, 6)), 8'($urandom_range(0, 8)),
                     16'($urandom_range(0, 10)), 8'($urandom_range(0, 12)),
                     8'($urandom_range(0, 6)), 16'($urandom_range(0, 15)));
      stall_request = 1'b1;
      run_random(70);
   endtask

   task automatic check_bit(input string name, input logic want, input logic got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : status_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            error_count++;
            $display("%0t: status transaction with none expected", $time);
         end else begin
            want = expected_status.pop_front();
            check_bit("alarm_on", want.alarm_on, rsp_alarm_on);
            check_bit("locked", want.locked, rsp_locked);
            check_bit("child_mode", want.child_mode, rsp_child_mode);
            check_bit("child_toggle_pulse", want.child_toggle_pulse, rsp_child_toggle_pulse);
            check_bit("calibrating", want.calibrating, rsp_calibrating);
         end
      end
   end

   // status side: random stalls, plus a long hold-off on request
   initial begin : status_sink
      int n;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         n = 0;
         if (stall_request) begin
            stall_request = 1'b0;
            n = HOLDOFF_CYCLES;
         end else if (sink_idling && $urandom_range(0, 99) >= 65) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_key_primary   = 8'd0;
      req_key_secondary = 8'd0;
      req_pad_busy_a    = 1'b0;
      req_pad_busy_b    = 1'b0;
      req_motor_run_a   = 1'b0;
      req_motor_run_b   = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      error_count       = 0;
      items_sent        = 0;
      sender_idling     = 1'b1;
      sink_idling       = 1'b1;
      stall_request     = 1'b0;
      clear_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_settings();
      test_directed();
      test_backpressure();
      test_hold_saturation();
      test_settings_sweep();

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
